/* rtl/bm25ts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 term scorer package
// Shared widths, register indexes, operation codes and the command record
// passed to the serial multiply and divide unit.
// ----------------------------------------------------------------------------
package bm25ts_pkg;

   localparam int TERMS_DEFAULT = 256;

   // Working width of products and dividends, and of divisors.
   localparam int ACC_W = 80;
   localparam int DIV_W = 60;

   // ln(2) in Q0.30.
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   localparam logic [1:0] CSR_DOC_COUNT   = 2'd0;
   localparam logic [1:0] CSR_AVG_DOC_LEN = 2'd1;
   localparam logic [1:0] CSR_K1_COEF     = 2'd2;
   localparam logic [1:0] CSR_B_COEF      = 2'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SCORE = 1'b1;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_kind_type;

   typedef struct packed {
      alu_kind_type     kind;
      logic             round_half;
      logic [ACC_W-1:0] opa;
      logic [DIV_W-1:0] opb;
   } alu_cmd_type;

   function automatic alu_cmd_type make_cmd(alu_kind_type kind, logic rnd,
                                            logic [ACC_W-1:0] opa,
                                            logic [DIV_W-1:0] opb);
      alu_cmd_type c;
      c.kind       = kind;
      c.round_half = rnd;
      c.opa        = opa;
      c.opb        = opb;
      return c;
   endfunction

   // Apply a sign to a magnitude and saturate to a signed 32-bit result.
   function automatic logic [31:0] sat32(logic [ACC_W-1:0] mag, logic neg);
      logic big;
      logic [31:0] res;
      big = |mag[ACC_W-1:31];
      if (neg) begin
         res = big ? 32'h8000_0000 : (32'd0 - mag[31:0]);
      end else begin
         res = (big || (mag[30:0] == 31'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return res;
   endfunction

endpackage

/* rtl/bm25_term_scorer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 term scorer
// Fixed-point Okapi BM25: per-slot idf and upper bound tables, partial scores.
// ----------------------------------------------------------------------------
// Usage:
// Registers are written through the csr_ channel (csr_valid, csr_index,
// csr_wdata); csr_ready is always high, so no write is ever held off.
// Write them only while busy is low and no response is pending.
// A transaction is accepted when start is high and busy is low. A load
// (req_operation = 0) computes idf with two serial log2 evaluations, each a
// normalize and 24 squarings on the serial multiplier, then the upper bound;
// it writes both tables and answers (zeros and rsp_error if doc_freq exceeds
// the document count). A score (req_operation = 1) reads the slot, runs one
// floor division, four multiplications and a rounded division and answers
// (score 0 early if the denominator is 0). All work goes through one
// bit-serial multiply and divide unit, one bit per cycle, one transaction at
// a time. The result appears on the rsp_ ports for one cycle with rsp_valid;
// the receiver cannot stall it. A new transaction may start in that cycle.
// Reset returns the registers to their defaults and the sequencer to idle;
// the tables are not cleared, and a slot must be loaded before it is scored.
// ----------------------------------------------------------------------------
module bm25_term_scorer_top
   import bm25ts_pkg::*;
#(
   parameter int TERMS = TERMS_DEFAULT
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [7:0]         req_term_index,
   input  logic [31:0]        req_doc_freq,
   input  logic [15:0]        req_term_freq,
   input  logic [23:0]        req_doc_len,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_score,
   output logic signed [23:0] rsp_idf_value,
   output logic signed [31:0] rsp_upper_bound,
   output logic               rsp_error
);

   localparam int IDX_W = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam int MOD_W = IDX_W + 1;

   typedef enum logic [16:0] {
      S_IDLE     = 17'b00000000000000001,
      S_LD_CHECK = 17'b00000000000000010,
      S_NORM     = 17'b00000000000000100,
      S_SQUARE   = 17'b00000000000001000,
      S_LOG_END  = 17'b00000000000010000,
      S_LN       = 17'b00000000000100000,
      S_BD_SCALE = 17'b00000000001000000,
      S_BD_NUM   = 17'b00000000010000000,
      S_BD_KB    = 17'b00000000100000000,
      S_BD_DIV   = 17'b00000001000000000,
      S_SC_READ  = 17'b00000010000000000,
      S_SC_LR    = 17'b00000100000000000,
      S_SC_N     = 17'b00001000000000000,
      S_SC_KN    = 17'b00010000000000000,
      S_SC_T1    = 17'b00100000000000000,
      S_SC_T2    = 17'b01000000000000000,
      S_SC_DIV   = 17'b10000000000000000
   } state_type;

   state_type          state_ff, state_in;

   logic [31:0]        doc_count_ff;
   logic [31:0]        avg_len_ff;
   logic [15:0]        k1_ff;
   logic [16:0]        b_coef_ff;

   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [31:0]        df_ff, df_in;
   logic [15:0]        tf_ff, tf_in;
   logic [23:0]        len_ff, len_in;

   logic [32:0]        norm_ff, norm_in;
   logic [5:0]         exp_ff, exp_in;
   logic [23:0]        frac_ff, frac_in;
   logic [4:0]         step_ff, step_in;
   logic               log_sel_ff, log_sel_in;
   logic [29:0]        ln_num_ff, ln_num_in;
   logic               ln_neg_ff, ln_neg_in;

   logic [23:0]        idf_ff, idf_in;
   logic [31:0]        bound_ff, bound_in;
   logic [ACC_W-1:0]   num_ff, num_in;
   logic [DIV_W-1:0]   den_ff, den_in;

   logic               alu_go_ff, alu_go_in;
   alu_cmd_type        alu_cmd_ff, alu_cmd_in;
   logic               alu_done;
   logic [ACC_W-1:0]   alu_result;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_score_ff, rsp_score_in;
   logic [23:0]        rsp_idf_ff, rsp_idf_in;
   logic [31:0]        rsp_bound_ff, rsp_bound_in;
   logic               rsp_error_ff, rsp_error_in;

   logic [23:0]        idf_mem [TERMS];
   logic [31:0]        bound_mem [TERMS];
   logic [23:0]        idf_rd_ff;
   logic [31:0]        bound_rd_ff;
   logic               mem_we;
   logic [23:0]        idf_wr;
   logic [31:0]        bound_wr;

   logic [MOD_W-1:0]   mod_r;
   logic [31:0]        avg_eff;
   logic [16:0]        b_eff;
   logic [16:0]        k1_plus;
   logic [31:0]        sq;
   logic [30:0]        mant_next;
   logic [29:0]        log_val;
   logic [29:0]        ln_diff;
   logic               diff_neg;
   logic [60:0]        ln_round;
   logic [22:0]        ln_mag;
   logic [23:0]        idf_mag;
   logic [42:0]        n_val;
   logic [DIV_W-1:0]   den_val;

   // Slot is term_index modulo TERMS, one restoring step per index bit.
   always_comb begin
      mod_r = '0;
      for (int i = 7; i >= 0; i--) begin
         mod_r = {mod_r[IDX_W-1:0], req_term_index[i]};
         if (mod_r >= MOD_W'(TERMS)) begin
            mod_r = mod_r - MOD_W'(TERMS);
         end
      end
   end

   assign avg_eff = (avg_len_ff < 32'd256) ? 32'd256 : avg_len_ff;
   assign b_eff   = (b_coef_ff > 17'd65536) ? 17'd65536 : b_coef_ff;
   assign k1_plus = {1'b0, k1_ff} + 17'd4096;
   assign idf_mag = idf_ff[23] ? (24'd0 - idf_ff) : idf_ff;

   assign sq        = alu_result[61:30];
   assign mant_next = sq[31] ? sq[31:1] : sq[30:0];
   assign log_val   = {exp_ff, frac_ff};
   assign diff_neg  = ln_num_ff < log_val;
   assign ln_diff   = diff_neg ? (log_val - ln_num_ff) : (ln_num_ff - log_val);
   assign ln_round  = {1'b0, alu_result[59:0]} + (61'd1 << 37);
   assign ln_mag    = ln_round[60:38];
   assign n_val     = {26'd0, 17'h10000 - b_eff} + alu_result[58:16];
   assign den_val   = DIV_W'({tf_ff, 28'd0}) + alu_result[DIV_W-1:0];

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      df_in        = df_ff;
      tf_in        = tf_ff;
      len_in       = len_ff;
      norm_in      = norm_ff;
      exp_in       = exp_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      log_sel_in   = log_sel_ff;
      ln_num_in    = ln_num_ff;
      ln_neg_in    = ln_neg_ff;
      idf_in       = idf_ff;
      bound_in     = bound_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      alu_go_in    = 1'b0;
      alu_cmd_in   = alu_cmd_ff;
      rsp_valid_in = 1'b0;
      rsp_score_in = rsp_score_ff;
      rsp_idf_in   = rsp_idf_ff;
      rsp_bound_in = rsp_bound_ff;
      rsp_error_in = rsp_error_ff;
      mem_we       = 1'b0;
      idf_wr       = idf_ff;
      bound_wr     = bound_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               slot_in  = mod_r[IDX_W-1:0];
               df_in    = req_doc_freq;
               tf_in    = req_term_freq;
               len_in   = req_doc_len;
               state_in = (req_operation == OP_SCORE) ? S_SC_READ : S_LD_CHECK;
            end
         end
         S_LD_CHECK: begin
            if (df_ff > doc_count_ff) begin
               mem_we       = 1'b1;
               idf_wr       = '0;
               bound_wr     = '0;
               rsp_valid_in = 1'b1;
               rsp_score_in = '0;
               rsp_idf_in   = '0;
               rsp_bound_in = '0;
               rsp_error_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               norm_in    = {doc_count_ff - df_ff, 1'b1};
               exp_in     = 6'd32;
               log_sel_in = 1'b0;
               state_in   = S_NORM;
            end
         end
         S_NORM: begin
            // Shift the argument up until its top bit sits at bit 32.
            if (norm_ff[32]) begin
               frac_in    = '0;
               step_in    = 5'd23;
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(norm_ff[32:2]),
                                     DIV_W'(norm_ff[32:2]));
               state_in   = S_SQUARE;
            end else begin
               norm_in = {norm_ff[31:0], 1'b0};
               exp_in  = exp_ff - 1'b1;
            end
         end
         S_SQUARE: begin
            if (alu_done) begin
               frac_in = {frac_ff[22:0], sq[31]};
               if (step_ff == '0) begin
                  state_in = S_LOG_END;
               end else begin
                  step_in    = step_ff - 1'b1;
                  alu_go_in  = 1'b1;
                  alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(mant_next),
                                        DIV_W'(mant_next));
               end
            end
         end
         S_LOG_END: begin
            if (!log_sel_ff) begin
               ln_num_in  = log_val;
               norm_in    = {df_ff, 1'b1};
               exp_in     = 6'd32;
               log_sel_in = 1'b1;
               state_in   = S_NORM;
            end else begin
               ln_neg_in  = diff_neg;
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(LN2_Q30), DIV_W'(ln_diff));
               state_in   = S_LN;
            end
         end
         S_LN: begin
            // The rounded magnitude fits 23 bits, so no clamp is reached.
            if (alu_done) begin
               idf_in     = ln_neg_ff ? (24'd0 - {1'b0, ln_mag}) : {1'b0, ln_mag};
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(ln_mag), DIV_W'(k1_plus));
               state_in   = S_BD_SCALE;
            end
         end
         S_BD_SCALE: begin
            if (alu_done) begin
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, alu_result,
                                     DIV_W'({avg_eff, 8'd0}));
               state_in   = S_BD_NUM;
            end
         end
         S_BD_NUM: begin
            if (alu_done) begin
               num_in     = alu_result;
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(b_eff), DIV_W'(k1_ff));
               state_in   = S_BD_KB;
            end
         end
         S_BD_KB: begin
            if (alu_done) begin
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_DIV, 1'b1, num_ff,
                                     DIV_W'({avg_eff, 20'd0}) + alu_result[DIV_W-1:0]);
               state_in   = S_BD_DIV;
            end
         end
         S_BD_DIV: begin
            if (alu_done) begin
               mem_we       = 1'b1;
               idf_wr       = idf_ff;
               bound_wr     = sat32(alu_result, idf_ff[23]);
               rsp_valid_in = 1'b1;
               rsp_score_in = '0;
               rsp_idf_in   = idf_ff;
               rsp_bound_in = sat32(alu_result, idf_ff[23]);
               rsp_error_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_SC_READ: begin
            alu_go_in  = 1'b1;
            alu_cmd_in = make_cmd(ALU_DIV, 1'b0, ACC_W'({len_ff, 24'd0}),
                                  DIV_W'(avg_eff));
            state_in   = S_SC_LR;
         end
         S_SC_LR: begin
            // Table read data is valid from the first cycle of this state.
            idf_in   = idf_rd_ff;
            bound_in = bound_rd_ff;
            if (alu_done) begin
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, alu_result, DIV_W'(b_eff));
               state_in   = S_SC_N;
            end
         end
         S_SC_N: begin
            if (alu_done) begin
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(n_val), DIV_W'(k1_ff));
               state_in   = S_SC_KN;
            end
         end
         S_SC_KN: begin
            if (alu_done) begin
               den_in = den_val;
               if (den_val == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_score_in = '0;
                  rsp_idf_in   = idf_ff;
                  rsp_bound_in = bound_ff;
                  rsp_error_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  alu_go_in  = 1'b1;
                  alu_cmd_in = make_cmd(ALU_MUL, 1'b0, ACC_W'(idf_mag), DIV_W'(tf_ff));
                  state_in   = S_SC_T1;
               end
            end
         end
         S_SC_T1: begin
            if (alu_done) begin
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_MUL, 1'b0, alu_result, DIV_W'(k1_plus));
               state_in   = S_SC_T2;
            end
         end
         S_SC_T2: begin
            if (alu_done) begin
               alu_go_in  = 1'b1;
               alu_cmd_in = make_cmd(ALU_DIV, 1'b1, {alu_result[ACC_W-17:0], 16'd0},
                                     den_ff);
               state_in   = S_SC_DIV;
            end
         end
         S_SC_DIV: begin
            if (alu_done) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = sat32(alu_result, idf_ff[23]);
               rsp_idf_in   = idf_ff;
               rsp_bound_in = bound_ff;
               rsp_error_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alu_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alu_go_ff    <= alu_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff      <= slot_in;
      df_ff        <= df_in;
      tf_ff        <= tf_in;
      len_ff       <= len_in;
      norm_ff      <= norm_in;
      exp_ff       <= exp_in;
      frac_ff      <= frac_in;
      step_ff      <= step_in;
      log_sel_ff   <= log_sel_in;
      ln_num_ff    <= ln_num_in;
      ln_neg_ff    <= ln_neg_in;
      idf_ff       <= idf_in;
      bound_ff     <= bound_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      alu_cmd_ff   <= alu_cmd_in;
      rsp_score_ff <= rsp_score_in;
      rsp_idf_ff   <= rsp_idf_in;
      rsp_bound_ff <= rsp_bound_in;
      rsp_error_ff <= rsp_error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         doc_count_ff <= 32'd1;
         avg_len_ff   <= 32'd256;
         k1_ff        <= 16'd4915;
         b_coef_ff    <= 17'd49152;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DOC_COUNT:   doc_count_ff <= csr_wdata;
            CSR_AVG_DOC_LEN: avg_len_ff   <= csr_wdata;
            CSR_K1_COEF:     k1_ff        <= csr_wdata[15:0];
            CSR_B_COEF:      b_coef_ff    <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         idf_mem[slot_ff]   <= idf_wr;
         bound_mem[slot_ff] <= bound_wr;
      end
      idf_rd_ff   <= idf_mem[slot_ff];
      bound_rd_ff <= bound_mem[slot_ff];
   end

   bm25ts_serial_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd_go (alu_go_ff),
      .cmd    (alu_cmd_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign csr_ready       = 1'b1;
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_score       = rsp_score_ff;
   assign rsp_idf_value   = rsp_idf_ff;
   assign rsp_upper_bound = rsp_bound_ff;
   assign rsp_error       = rsp_error_ff;

endmodule

/* rtl/bm25ts_serial_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 serial arithmetic unit
// Shift-and-add multiplier (one multiplier bit per cycle) and restoring
// divider (one quotient bit per cycle) with optional round-half-up.
// ----------------------------------------------------------------------------
module bm25ts_serial_alu
   import bm25ts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_go,
   input  alu_cmd_type      cmd,
   output logic             done,
   output logic [ACC_W-1:0] result
);

   localparam int CNT_W = $clog2(ACC_W);

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_MUL  = 4'b0010,
      A_DIV  = 4'b0100,
      A_FIX  = 4'b1000
   } alu_state_type;

   alu_state_type    state_ff, state_in;
   alu_kind_type     kind_ff, kind_in;
   logic             round_ff, round_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] a_ff, a_in;
   logic [DIV_W-1:0] b_ff, b_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_sh;
   logic             qbit;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      round_in = round_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      rem_sh   = {rem_ff[DIV_W-1:0], a_ff[ACC_W-1]};
      qbit     = 1'b0;
      case (state_ff)
         A_IDLE: begin
            if (cmd_go) begin
               kind_in  = cmd.kind;
               round_in = cmd.round_half;
               acc_in   = '0;
               a_in     = cmd.opa;
               b_in     = cmd.opb;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = (cmd.kind == ALU_MUL) ? A_MUL : A_DIV;
            end
         end
         A_MUL: begin
            // Stops as soon as no multiplier bits are left.
            if (b_ff == '0) begin
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = {a_ff[ACC_W-2:0], 1'b0};
               b_in = {1'b0, b_ff[DIV_W-1:1]};
            end
         end
         A_DIV: begin
            if (rem_sh >= {1'b0, b_ff}) begin
               rem_in = rem_sh - {1'b0, b_ff};
               qbit   = 1'b1;
            end else begin
               rem_in = rem_sh;
            end
            // The dividend shifts out at the top while quotient bits enter below.
            a_in   = {a_ff[ACC_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            if (round_ff && ({rem_ff, 1'b0} >= {2'b0, b_ff})) begin
               a_in = a_ff + 1'b1;
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      kind_ff  <= kind_in;
      round_ff <= round_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign done   = done_ff;
   assign result = (kind_ff == ALU_MUL) ? acc_ff : a_ff;

endmodule
